[rtl/note_stack_priority_macros.svh]
// Assertion macros shared by the note stack RTL.
`ifndef NOTE_STACK_PRIORITY_MACROS_SVH
`define NOTE_STACK_PRIORITY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nsp_pkg.sv]
// Types and constants for the note stack and its cells.
`timescale 1ns / 1ps
`default_nettype none

package nsp_pkg;

    // Stored entry: note in the low bits, released mark, tag on top.
    typedef struct packed {
        logic [7:0] tag;
        logic       rel;
        logic [6:0] note;
    } t_entry;

    typedef enum logic [2:0] {
        MODE_TOP         = 3'd0,
        MODE_BOTTOM      = 3'd1,
        MODE_TOP_HOLD    = 3'd2,
        MODE_BOTTOM_HOLD = 3'd3,
        MODE_SORTED      = 3'd4,
        MODE_SORTED_HOLD = 3'd5
    } t_mode;

    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_ALL  = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;

    localparam logic [2:0] MODE_RESET = 3'd0;
    localparam logic [4:0] SIZE_RESET = 5'd16;

    typedef enum logic [3:0] {
        CO_IDLE,
        CO_CLEAR,
        CO_SEARCH_EQ,
        CO_SEARCH_GT,
        CO_REMOVE,
        CO_MARK,
        CO_WRITE_HIT,
        CO_INSERT_TOP,
        CO_INSERT_HIT,
        CO_WRITE_AT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   entry;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH1,
        S_OP1,
        S_SRCH2,
        S_OP2,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/nsp_cell.sv]
// One stack position: holds an entry, a search hit flag, and moves data with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module nsp_cell #(
    parameter int CELL_INDEX = 0,
    parameter int DEPTH      = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  nsp_pkg::t_cell_cmd                  i_cmd,
    input  wire [$clog2(DEPTH+1)-1:0]           i_count,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_pos,
    input  nsp_pkg::t_entry                     i_left,
    input  nsp_pkg::t_entry                     i_right,
    input  wire                                 i_pre,
    output logic                                o_pre,
    input  wire                                 i_aft,
    output logic                                o_aft,
    input  wire                                 i_unr,
    output logic                                o_unr,
    output nsp_pkg::t_entry                     o_entry
);
    import nsp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] K  = CW'(CELL_INDEX);
    localparam logic [IW-1:0] KI = IW'(CELL_INDEX);

    t_entry r_entry, n_entry;
    logic   r_hit, n_hit;
    logic   w_valid, w_cond;

    always_comb begin
        w_valid = (K < i_count);
        case (i_cmd.op)
            CO_SEARCH_EQ: w_cond = w_valid && (r_entry.note == i_cmd.entry.note);
            CO_SEARCH_GT: w_cond = w_valid && (r_entry.note > i_cmd.entry.note);
            default:      w_cond = 1'b0;
        endcase
        o_pre = i_pre | w_cond;
        o_aft = i_aft | r_hit;
        o_unr = i_unr | (w_valid && !r_entry.rel);
    end

    always_comb begin
        n_entry = r_entry;
        n_hit   = r_hit;
        case (i_cmd.op)
            CO_CLEAR: n_entry = '0;
            CO_SEARCH_EQ, CO_SEARCH_GT: n_hit = w_cond && !i_pre;
            CO_REMOVE: begin
                // close the gap: take from the right, last live entry drops to zero
                if ((i_aft || r_hit) && w_valid) begin
                    if (K == i_count - CW'(1)) n_entry = '0;
                    else                       n_entry = i_right;
                end
            end
            CO_MARK:      if (r_hit) n_entry.rel = 1'b1;
            CO_WRITE_HIT: if (r_hit) n_entry = i_cmd.entry;
            CO_INSERT_TOP: begin
                if (CELL_INDEX == 0) n_entry = i_cmd.entry;
                else if (w_valid)    n_entry = i_left;
            end
            CO_INSERT_HIT: begin
                if (r_hit)                 n_entry = i_cmd.entry;
                else if (i_aft && w_valid) n_entry = i_left;
            end
            CO_WRITE_AT: if (KI == i_pos) n_entry = i_cmd.entry;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_hit   <= n_hit;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[rtl/note_stack_priority.sv]
// Top level of the note priority stack: sequencer, configuration and the row of cells.
`timescale 1ns / 1ps
`default_nettype none
`include "note_stack_priority_macros.svh"

// A command is taken when start is high and busy is low. Busy then stays high until the
// result has been shown: o_strobe is high for exactly one cycle, with status, fill count
// and the entry at position zero, and the receiver must take it in that cycle. Each
// position of the stack is a cell that searches, shifts and writes in step with its
// neighbours. Clear and unused commands go straight to the result. A release
// searches, then removes or marks the note; a hold mode that finds it searches again
// for the status. A push searches, removes a match and inserts; sorted modes search
// for the place first, and a hold mode that finds the note rewrites it. Configuration
// writes are always ready and must only be made while busy is low.
module note_stack_priority #(
    parameter int STACK_DEPTH = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_command,
    input  wire  [6:0]                          i_note,
    input  wire  [7:0]                          i_tag,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [1:0]                          i_cfg_index,
    input  wire  [4:0]                          i_cfg_data,
    output logic                                o_strobe,
    output logic [1:0]                          o_status,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    o_fill_count,
    output logic [6:0]                          o_first_note,
    output logic [7:0]                          o_first_tag,
    output logic                                o_first_released
);
    import nsp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_state          r_state, n_state;
    logic [2:0]      r_mode;
    logic [4:0]      r_size_cfg;
    logic [1:0]      r_cmd;
    logic [6:0]      r_note;
    logic [7:0]      r_tag;
    t_mode           r_emode;
    logic [CW-1:0]   r_size;
    logic [CW-1:0]   r_count, n_count;
    logic [1:0]      r_status, n_status;
    logic            r_found;

    t_mode           w_emode;
    logic [CW-1:0]   w_size;
    logic [CW-1:0]   w_count_up;
    logic            w_hold, w_top, w_sorted;
    t_cell_cmd       w_cmd;
    logic [CW-1:0]   w_ccount;
    logic [IW-1:0]   w_pos;

    t_entry          w_entry [STACK_DEPTH];
    logic [STACK_DEPTH:0] w_pre, w_aft, w_unr;

    function automatic logic [IW-1:0] w_size_last(input logic [CW-1:0] s);
        logic [CW-1:0] t;
        t = s - CW'(1);
        return t[IW-1:0];
    endfunction

    // Clamp the size register and fold unused modes onto top mode.
    always_comb begin
        if (r_size_cfg == 5'd0)
            w_size = CW'(1);
        else if (32'(r_size_cfg) > 32'(STACK_DEPTH))
            w_size = CW'(STACK_DEPTH);
        else
            w_size = CW'(r_size_cfg);
        if (r_mode > MODE_SORTED_HOLD) w_emode = MODE_TOP;
        else                           w_emode = t_mode'(r_mode);
    end

    always_comb begin
        w_hold     = r_emode inside {MODE_TOP_HOLD, MODE_BOTTOM_HOLD, MODE_SORTED_HOLD};
        w_top      = r_emode inside {MODE_TOP, MODE_TOP_HOLD};
        w_sorted   = r_emode inside {MODE_SORTED, MODE_SORTED_HOLD};
        w_count_up = (r_count < r_size) ? r_count + CW'(1) : r_count;
        w_pos      = (r_count < r_size) ? r_count[IW-1:0] : w_size_last(r_size);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_PUSH || i_command == CMD_RELEASE) n_state = S_SRCH1;
                    else                                                   n_state = S_DONE;
                end
            end
            S_SRCH1: n_state = S_OP1;
            S_OP1: begin
                if (r_cmd == CMD_RELEASE)
                    n_state = (r_found && w_hold) ? S_SRCH2 : S_DONE;
                else if (r_found && w_hold)
                    n_state = S_DONE;
                else if (w_sorted)
                    n_state = S_SRCH2;
                else
                    n_state = S_OP2;
            end
            S_SRCH2: n_state = (r_cmd == CMD_RELEASE) ? S_DONE : S_OP2;
            S_OP2:   n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Cell commands, count and status.
    always_comb begin
        w_cmd.op    = CO_IDLE;
        w_cmd.entry = '{tag: r_tag, rel: 1'b0, note: r_note};
        w_ccount    = r_count;
        n_count     = r_count;
        n_status    = r_status;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = STAT_NONE;
                    if (i_command == CMD_CLEAR) begin
                        w_cmd.op = CO_CLEAR;
                        n_count  = '0;
                    end else if (r_count > w_size) begin
                        // drop entries above a lowered size
                        n_count = w_size;
                    end
                end
            end
            S_SRCH1: w_cmd.op = CO_SEARCH_EQ;
            S_OP1: begin
                if (r_found) begin
                    if (w_hold) begin
                        w_cmd.op = (r_cmd == CMD_RELEASE) ? CO_MARK : CO_WRITE_HIT;
                    end else begin
                        w_cmd.op = CO_REMOVE;
                        n_count  = r_count - CW'(1);
                        if (r_cmd == CMD_RELEASE) n_status = STAT_DONE;
                    end
                end
            end
            S_SRCH2: begin
                w_cmd.op = CO_SEARCH_GT;
                if (r_cmd == CMD_RELEASE)
                    n_status = w_unr[STACK_DEPTH] ? STAT_DONE : STAT_ALL;
            end
            S_OP2: begin
                n_count  = w_count_up;
                w_ccount = w_count_up;
                if (w_top)                  w_cmd.op = CO_INSERT_TOP;
                else if (w_sorted && r_found) w_cmd.op = CO_INSERT_HIT;
                else                        w_cmd.op = CO_WRITE_AT;
            end
            default: ;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        busy             = (r_state != S_IDLE);
        o_strobe         = (r_state == S_DONE);
        o_cfg_ready      = 1'b1;
        o_status         = r_status;
        o_fill_count     = r_count;
        o_first_note     = w_entry[0].note;
        o_first_tag      = w_entry[0].tag;
        o_first_released = w_entry[0].rel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_RESET;
            r_size_cfg <= SIZE_RESET;
            r_count    <= '0;
            r_status   <= STAT_NONE;
            r_found    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (r_state == S_SRCH1 || r_state == S_SRCH2) r_found <= w_pre[STACK_DEPTH];
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MODE)      r_mode     <= i_cfg_data[2:0];
                else if (i_cfg_index == CFG_SIZE) r_size_cfg <= i_cfg_data;
            end
        end
    end

    // Hold the command fields for the whole transaction.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd   <= i_command;
            r_note  <= i_note;
            r_tag   <= i_tag;
            r_emode <= w_emode;
            r_size  <= w_size;
        end
    end

    assign w_pre[0] = 1'b0;
    assign w_aft[0] = 1'b0;
    assign w_unr[0] = 1'b0;

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        t_entry w_left, w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end
        nsp_cell #(
            .CELL_INDEX (k),
            .DEPTH      (STACK_DEPTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_count (w_ccount),
            .i_pos   (w_pos),
            .i_left  (w_left),
            .i_right (w_right),
            .i_pre   (w_pre[k]),
            .o_pre   (w_pre[k+1]),
            .i_aft   (w_aft[k]),
            .o_aft   (w_aft[k+1]),
            .i_unr   (w_unr[k]),
            .o_unr   (w_unr[k+1]),
            .o_entry (w_entry[k])
        );
    end

    `NSP_ASSERT_NOW(a_fill_in_size, o_strobe, r_count <= r_size, "fill count above size")
    `NSP_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result strobe longer than a cycle")
    `NSP_ASSERT_NEXT(a_remove_shrinks,
        r_state == S_OP1 && r_cmd == CMD_RELEASE && !w_hold && r_found,
        r_count == $past(r_count) - CW'(1), "removal did not shrink the stack")
    `NSP_ASSERT_NOW(a_empty_reads_zero, o_strobe && o_fill_count == '0,
        o_first_note == 7'd0 && o_first_tag == 8'd0 && !o_first_released,
        "empty stack shows an entry")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the note priority stack: scoreboard, stimulus and result checks.
`timescale 1ns / 1ps

module tb;
    import nsp_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] fill;
        logic [6:0] note;
        logic [7:0] tag;
        logic       rel;
    } t_outcome;

    class note_stack_board;
        t_entry     slot [STACK_DEPTH];
        int         fill;
        logic [2:0] mode_reg;
        logic [4:0] size_reg;
        t_outcome   awaited [$];
        int         fails;

        function new();
            foreach (slot[i]) slot[i] = '0;
            fill     = 0;
            mode_reg = MODE_RESET;
            size_reg = SIZE_RESET;
            fails    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [4:0] data);
            if (idx == CFG_MODE) mode_reg = data[2:0];
            else if (idx == CFG_SIZE) size_reg = data;
        endfunction

        function int find_note(logic [6:0] n);
            for (int i = 0; i < fill; i++)
                if (slot[i].note == n) return i;
            return -1;
        endfunction

        // Hold modes only mark the entry; otherwise close the gap.
        function logic [1:0] release_note(logic [6:0] n, bit hold);
            int hit;
            hit = find_note(n);
            if (hit < 0) return STAT_NONE;
            if (hold) begin
                slot[hit].rel = 1'b1;
                for (int j = 0; j < fill; j++)
                    if (!slot[j].rel) return STAT_DONE;
                return STAT_ALL;
            end
            for (int j = hit; j + 1 < fill; j++) slot[j] = slot[j + 1];
            fill--;
            slot[fill] = '0;
            return STAT_DONE;
        endfunction

        function void insert_at(int pos, t_entry e, int limit);
            if (fill < limit) fill++;
            for (int i = fill - 1; i > pos; i--) slot[i] = slot[i - 1];
            slot[pos] = e;
        endfunction

        function void push_note(logic [6:0] n, logic [7:0] tag, t_mode mode, bit hold,
                                int limit);
            t_entry     e;
            int         hit;
            int         pos;
            e.tag  = tag;
            e.rel  = 1'b0;
            e.note = n;
            if (hold) begin
                hit = find_note(n);
                if (hit >= 0) begin
                    slot[hit] = e;
                    return;
                end
            end else begin
                void'(release_note(n, 1'b0));
            end
            case (mode)
                MODE_BOTTOM, MODE_BOTTOM_HOLD: begin
                    if (fill < limit) begin
                        slot[fill] = e;
                        fill++;
                    end else begin
                        slot[limit - 1] = e;
                    end
                end
                MODE_SORTED, MODE_SORTED_HOLD: begin
                    pos = 0;
                    while (pos < fill && slot[pos].note <= n) pos++;
                    if (pos == fill) begin
                        if (fill >= limit) begin
                            slot[limit - 1] = e;
                        end else begin
                            slot[fill] = e;
                            fill++;
                        end
                    end else begin
                        insert_at(pos, e, limit);
                    end
                end
                default: insert_at(0, e, limit);
            endcase
        endfunction

        function void note_command(logic [1:0] cmd, logic [6:0] n, logic [7:0] tag);
            int       limit;
            t_mode    mode;
            bit       hold;
            t_outcome r;
            limit = size_reg;
            if (limit < 1) limit = 1;
            if (limit > STACK_DEPTH) limit = STACK_DEPTH;
            mode = (mode_reg > MODE_SORTED_HOLD) ? MODE_TOP : t_mode'(mode_reg);
            hold = (mode == MODE_TOP_HOLD || mode == MODE_BOTTOM_HOLD ||
                    mode == MODE_SORTED_HOLD);
            r.status = STAT_NONE;
            // Drop entries beyond a lowered size.
            if (fill > limit) fill = limit;
            case (cmd)
                CMD_PUSH:    push_note(n, tag, mode, hold, limit);
                CMD_RELEASE: r.status = release_note(n, hold);
                CMD_CLEAR: begin
                    foreach (slot[i]) slot[i] = '0;
                    fill = 0;
                end
                default: ;
            endcase
            r.fill = 5'(fill);
            r.note = slot[0].note;
            r.tag  = slot[0].tag;
            r.rel  = slot[0].rel;
            awaited.push_back(r);
        endfunction

        function void compare_field(string label, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", label, want, got);
                fails++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [4:0] fill_v, logic [6:0] n,
                                   logic [7:0] tag, logic rel);
            t_outcome want;
            if (awaited.size() == 0) begin
                $error("result with no transaction outstanding");
                fails++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 8'(want.status), 8'(status));
            compare_field("fill_count", 8'(want.fill), 8'(fill_v));
            compare_field("first_note", 8'(want.note), 8'(n));
            compare_field("first_tag", want.tag, tag);
            compare_field("first_released", 8'(want.rel), 8'(rel));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_command = '0;
    logic [6:0] i_note = '0;
    logic [7:0] i_tag = '0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [4:0] i_cfg_data = '0;
    logic       o_strobe;
    logic [1:0] o_status;
    logic [4:0] o_fill_count;
    logic [6:0] o_first_note;
    logic [7:0] o_first_tag;
    logic       o_first_released;

    note_stack_board board = new();
    bit idling_on;
    int issued;
    int cycle_count;

    note_stack_priority #(.STACK_DEPTH(STACK_DEPTH)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_note           (i_note),
        .i_tag            (i_tag),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_fill_count     (o_fill_count),
        .o_first_note     (o_first_note),
        .o_first_tag      (o_first_tag),
        .o_first_released (o_first_released)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_result(o_status, o_fill_count, o_first_note, o_first_tag,
                               o_first_released);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb failed");
        $finish;
    end

    // Hold start until the transaction is taken, then idle for a burst now and then.
    task automatic issue(input logic [1:0] cmd, input logic [6:0] n, input logic [7:0] tag);
        start     <= 1'b1;
        i_command <= cmd;
        i_note    <= n;
        i_tag     <= tag;
        do @(posedge i_clk); while (busy);
        board.note_command(cmd, n, tag);
        issued++;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (board.awaited.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
    endtask

    task automatic new_setting(input logic [2:0] mode_val, input logic [4:0] size_val,
                               input bit spare);
        drain();
        write_reg(CFG_MODE, {2'b00, mode_val});
        write_reg(CFG_SIZE, size_val);
        if (spare) write_reg(CFG_SPARE, 5'($urandom_range(0, 31)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int base, input int span);
        int         pick;
        logic [1:0] cmd;
        logic [6:0] n;
        pick = $urandom_range(0, 99);
        cmd  = (pick < 52) ? CMD_PUSH : (pick < 92) ? CMD_RELEASE :
               (pick < 97) ? CMD_CLEAR : CMD_NONE;
        n    = ($urandom_range(0, 3) == 0) ? 7'($urandom) :
                                             7'(base + $urandom_range(0, span));
        issue(cmd, n, 8'($urandom));
    endtask

    logic [2:0] plan_mode [12] = '{MODE_TOP, MODE_BOTTOM, MODE_TOP_HOLD, MODE_BOTTOM_HOLD,
                                   MODE_SORTED, MODE_SORTED_HOLD, MODE_SPARE6, MODE_SPARE7,
                                   MODE_TOP, MODE_SORTED_HOLD, MODE_BOTTOM_HOLD,
                                   MODE_SORTED};
    logic [4:0] plan_size [12] = '{5'd16, 5'd4, 5'd3, 5'd5, 5'd4, 5'd6, 5'd2, 5'd16,
                                   5'd0, 5'd31, 5'd1, 5'd17};

    initial begin
        int         phase;
        int         span;
        int         base;
        int         count;
        int         pick;
        logic [2:0] mode_val;
        logic [4:0] size_val;

        issued    = 0;
        idling_on = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty release, field extremes, duplicate push, miss, spare command, clear.
        issue(CMD_RELEASE, 7'd5, 8'h00);
        issue(CMD_PUSH, 7'd0, 8'h00);
        issue(CMD_PUSH, 7'd127, 8'hFF);
        issue(CMD_PUSH, 7'd64, 8'h5A);
        issue(CMD_PUSH, 7'd0, 8'hA5);
        issue(CMD_RELEASE, 7'd127, 8'h00);
        issue(CMD_RELEASE, 7'd99, 8'h00);
        issue(CMD_NONE, 7'h7F, 8'hFF);
        issue(CMD_CLEAR, 7'h00, 8'h00);
        // Top hold: full stack shifts out, refresh, then every note released.
        new_setting(MODE_TOP_HOLD, 5'd2, 1'b1);
        issue(CMD_PUSH, 7'd10, 8'h11);
        issue(CMD_PUSH, 7'd20, 8'h22);
        issue(CMD_PUSH, 7'd30, 8'h33);
        issue(CMD_PUSH, 7'd20, 8'h44);
        issue(CMD_RELEASE, 7'd20, 8'h00);
        issue(CMD_RELEASE, 7'd30, 8'h00);
        // Sorted: note above all overwrites the last entry, lower one shifts it out.
        new_setting(MODE_SORTED, 5'd3, 1'b0);
        issue(CMD_PUSH, 7'd50, 8'h01);
        issue(CMD_PUSH, 7'd20, 8'h02);
        issue(CMD_PUSH, 7'd90, 8'h03);
        issue(CMD_PUSH, 7'd100, 8'h04);
        issue(CMD_PUSH, 7'd10, 8'h05);
        issue(CMD_RELEASE, 7'd20, 8'h00);
        // Bottom: full stack overwrites its last entry.
        new_setting(MODE_BOTTOM, 5'd2, 1'b0);
        issue(CMD_PUSH, 7'd7, 8'h80);
        issue(CMD_PUSH, 7'd8, 8'h40);
        issue(CMD_PUSH, 7'd9, 8'h20);
        // Size lowered below the fill.
        new_setting(MODE_TOP, 5'd1, 1'b0);
        issue(CMD_NONE, 7'd0, 8'h00);

        phase = 0;
        while (issued < ITEM_TARGET) begin
            if (phase < 12) begin
                mode_val = plan_mode[phase];
                size_val = plan_size[phase];
            end else begin
                mode_val = 3'($urandom_range(0, 7));
                pick     = $urandom_range(0, 9);
                size_val = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd16 : (pick == 2) ? 5'd31 :
                           (pick == 3) ? 5'($urandom_range(17, 31)) :
                                         5'($urandom_range(1, 8));
            end
            new_setting(mode_val, size_val, $urandom_range(0, 7) == 0);
            idling_on = ($urandom_range(0, 2) != 0) && (issued < ITEM_TARGET - 150);
            span  = $urandom_range(4, 24);
            base  = $urandom_range(0, 127 - span);
            count = $urandom_range(20, 60);
            repeat (count) begin
                if (issued >= ITEM_TARGET - 150) idling_on = 1'b0;
                random_item(base, span);
                // Pause now and then until everything outstanding has come back.
                if ($urandom_range(0, 99) == 0) drain();
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (board.fails == 0 && board.awaited.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
